>>> hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared widths, command and status codes and controller states for the
// sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // default number of queue entries
  localparam int DEFAULT_DEPTH = 16;

  // field widths
  localparam int FUNC_W  = 2;
  localparam int KEY_W   = 34;
  localparam int PAY_W   = 32;
  localparam int STAT_W  = 3;
  localparam int SMALL_W = 5;

  // entry as stored in memory: key above payload
  localparam int ENTRY_W = KEY_W + PAY_W;

  // command codes
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_LIST   = 2'd2,
    FN_CLEAR  = 2'd3
  } func_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_CLEARED  = 3'd3,
    ST_ENTRY    = 3'd4
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_PUT,
    S_REMOVE,
    S_LIST
  } state_t;

endpackage

>>> hdl/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Simple dual-port entry memory: one write and one read a cycle, read data
// registered.
// ----------------------------------------------------------------------------
module spq_ram
  import spq_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [ENTRY_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded priority queue of DEPTH entries kept in ascending key order.
//
// A command word is taken when start is high and busy is low: insert, remove
// smallest, list all, or clear. Results leave on the out_ ports, each valid
// for exactly one cycle while out_valid is high; out_last marks the final
// result of a command. The receiver cannot stall, so no result is held back.
// Entries live in one circular memory (head, tail, count) with a registered
// read. Steps per command, from accept to its last result:
//   insert into empty/full queue, clear, empty remove/list: result at accept
//   remove: head entry read at accept, returned from S_REMOVE
//   insert: S_INS_SHIFT moves each held entry whose key is not smaller than
//     the new key up a slot, one entry per cycle through the memory port
//   list: one entry read and returned per cycle
// busy stays high until the last result has been registered, so the next
// command may start in the cycle that result appears.
// Reset empties the queue; memory contents are never cleared since no read
// reaches a slot above the count.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [PAY_W-1:0]   in_payload,
  // result channel
  output logic               out_valid,
  output logic [STAT_W-1:0]  out_status,
  output logic [SMALL_W-1:0] out_position,
  output logic [KEY_W-1:0]   out_entry_key,
  output logic [PAY_W-1:0]   out_entry_payload,
  output logic [SMALL_W-1:0] out_entry_count,
  output logic               out_last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // pointer wrap helpers
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  state_t state_r, state_nxt;

  logic [AW-1:0]      head_r, head_nxt;
  logic [AW-1:0]      tail_r, tail_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [PAY_W-1:0]   pay_r, pay_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [SMALL_W-1:0] out_position_r, out_position_nxt;
  logic [KEY_W-1:0]   out_key_r, out_key_nxt;
  logic [PAY_W-1:0]   out_pay_r, out_pay_nxt;
  logic [SMALL_W-1:0] out_count_r, out_count_nxt;
  logic               out_last_r, out_last_nxt;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic [KEY_W-1:0]   rd_key;
  logic [PAY_W-1:0]   rd_pay;

  logic               accept;
  logic               q_full;
  logic               q_empty;
  logic               ins_move;
  logic               list_last;
  logic [CW-1:0]      list_pos;

  // entry memory
  spq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // decoded conditions
  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign q_full    = (count_r == CW'(DEPTH));
  assign q_empty   = (count_r == '0);
  assign rd_key    = rd_data[ENTRY_W-1:PAY_W];
  assign rd_pay    = rd_data[PAY_W-1:0];
  assign ins_move  = (rd_key >= key_r);
  assign list_pos  = cnt_r + CW'(1);
  assign list_last = (list_pos == count_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (func_t'(in_func))
            FN_INSERT: if (!q_full && !q_empty) state_nxt = S_INS_SHIFT;
            FN_REMOVE: if (!q_empty) state_nxt = S_REMOVE;
            FN_LIST:   if (!q_empty) state_nxt = S_LIST;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS_SHIFT: begin
        if (!ins_move) begin
          state_nxt = S_IDLE;
        end else if (cnt_r == '0) begin
          state_nxt = S_INS_PUT;
        end
      end
      S_INS_PUT: state_nxt = S_IDLE;
      S_REMOVE:  state_nxt = S_IDLE;
      S_LIST:    if (list_last) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath, memory control and result words
  always_comb begin
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    count_nxt        = count_r;
    cnt_nxt          = cnt_r;
    rd_ptr_nxt       = rd_ptr_r;
    wr_ptr_nxt       = wr_ptr_r;
    key_nxt          = key_r;
    pay_nxt          = pay_r;
    out_valid_nxt    = 1'b0;
    out_status_nxt   = out_status_r;
    out_position_nxt = '0;
    out_key_nxt      = '0;
    out_pay_nxt      = '0;
    out_count_nxt    = SMALL_W'(count_r);
    out_last_nxt     = 1'b1;
    wr_en            = 1'b0;
    wr_addr          = wr_ptr_r;
    wr_data          = {key_r, pay_r};
    rd_en            = 1'b0;
    rd_addr          = rd_ptr_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (func_t'(in_func))
            FN_INSERT: begin
              key_nxt = in_key;
              pay_nxt = in_payload;
              if (q_full) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_FULL;
              end else if (q_empty) begin
                // first entry goes straight to the tail slot
                wr_en          = 1'b1;
                wr_addr        = tail_r;
                wr_data        = {in_key, in_payload};
                tail_nxt       = ptr_inc(tail_r);
                count_nxt      = count_r + CW'(1);
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_INSERTED;
                out_count_nxt  = SMALL_W'(count_r + CW'(1));
              end else begin
                // walk down from the tail, moving keys not smaller than the new one up a slot
                rd_en      = 1'b1;
                rd_addr    = ptr_dec(tail_r);
                rd_ptr_nxt = ptr_dec(tail_r);
                wr_ptr_nxt = tail_r;
                cnt_nxt    = count_r - CW'(1);
                tail_nxt   = ptr_inc(tail_r);
                count_nxt  = count_r + CW'(1);
              end
            end
            FN_REMOVE: begin
              if (q_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = head_r;
              end
            end
            FN_LIST: begin
              if (q_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = head_r;
                rd_ptr_nxt = ptr_inc(head_r);
                cnt_nxt    = '0;
              end
            end
            default: begin
              count_nxt      = '0;
              tail_nxt       = head_r;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_CLEARED;
              out_count_nxt  = '0;
            end
          endcase
        end
      end

      S_INS_SHIFT: begin
        wr_en = 1'b1;
        if (ins_move) begin
          // held key not smaller: move it up one slot
          wr_data    = rd_data;
          wr_ptr_nxt = rd_ptr_r;
          if (cnt_r != '0) begin
            rd_en      = 1'b1;
            rd_addr    = ptr_dec(rd_ptr_r);
            rd_ptr_nxt = ptr_dec(rd_ptr_r);
            cnt_nxt    = cnt_r - CW'(1);
          end
        end else begin
          // smaller key found: new entry goes just above it
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_INSERTED;
        end
      end

      S_INS_PUT: begin
        // new entry becomes the smallest
        wr_en          = 1'b1;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_INSERTED;
      end

      S_REMOVE: begin
        head_nxt         = ptr_inc(head_r);
        count_nxt        = count_r - CW'(1);
        out_valid_nxt    = 1'b1;
        out_status_nxt   = ST_ENTRY;
        out_position_nxt = SMALL_W'(1);
        out_key_nxt      = rd_key;
        out_pay_nxt      = rd_pay;
        out_count_nxt    = SMALL_W'(count_r - CW'(1));
      end

      S_LIST: begin
        out_valid_nxt    = 1'b1;
        out_status_nxt   = ST_ENTRY;
        out_position_nxt = SMALL_W'(list_pos);
        out_key_nxt      = rd_key;
        out_pay_nxt      = rd_pay;
        out_last_nxt     = list_last;
        if (!list_last) begin
          rd_en      = 1'b1;
          rd_addr    = rd_ptr_r;
          rd_ptr_nxt = ptr_inc(rd_ptr_r);
          cnt_nxt    = list_pos;
        end
      end

      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result payload registers
  always_ff @(posedge clk) begin
    cnt_r          <= cnt_nxt;
    rd_ptr_r       <= rd_ptr_nxt;
    wr_ptr_r       <= wr_ptr_nxt;
    key_r          <= key_nxt;
    pay_r          <= pay_nxt;
    out_status_r   <= out_status_nxt;
    out_position_r <= out_position_nxt;
    out_key_r      <= out_key_nxt;
    out_pay_r      <= out_pay_nxt;
    out_count_r    <= out_count_nxt;
    out_last_r     <= out_last_nxt;
  end

  // result word
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_position      = out_position_r;
  assign out_entry_key     = out_key_r;
  assign out_entry_payload = out_pay_r;
  assign out_entry_count   = out_count_r;
  assign out_last          = out_last_r;

endmodule
